[rtl/stli_pkg.sv]
package stli_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int ROW_BITS       = 32;
	localparam int ROW_SHIFT      = 5;

	localparam logic [1:0] ST_EXACT   = 2'd0;
	localparam logic [1:0] ST_INTERP  = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [11:0] {
		S_CLR  = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_STWR = 12'b000000000100,
		S_QHIT = 12'b000000001000,
		S_LOSC = 12'b000000010000,
		S_HISC = 12'b000000100000,
		S_VHI  = 12'b000001000000,
		S_VLO  = 12'b000010000000,
		S_MUL2 = 12'b000100000000,
		S_SUM  = 12'b001000000000,
		S_DIV  = 12'b010000000000,
		S_FIN  = 12'b100000000000
	} state_t;

endpackage

[rtl/sparse_table_linear_interp.sv]
// Sparse table with linear interpolation between exact slots.
// Input channel (in_valid/in_stall): func, index, value. func store writes value
// into slot index and marks it exact; a store beyond the table is dropped. func
// query returns one output item (result, status) on out_valid/out_stall.
// Status: exact, interpolated, missing neighbor on one side, or empty table.
// Valid bits live in a memory of 32-bit rows, values in a second memory; both
// are read into a register.
// Items are handled one at a time; in_stall stays high until an item is through.
// A store sets its valid bit in S_STWR. A query on an empty table or beyond the
// table goes straight to S_FIN, an exact hit via S_QHIT. An interpolated query
// scans rows below (S_LOSC) and above (S_HISC), reads both neighbors (S_VHI,
// S_VLO), then divides one quotient bit per cycle over the numerator (44 bits at
// 1024 slots) and applies the sign; the row scans dominate for sparse tables.
// Reset: a clearing pass zeroes one valid row per cycle, ceil(TABLE_SIZE/32)
// rows (32 at 1024 slots), with in_stall high throughout.
// The finished output item sits in an output register, so the next input item is
// taken while out_stall holds that result; a new result waits until it drains.
module sparse_table_linear_interp #(
	parameter int TABLE_SIZE = stli_pkg::TABLE_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [9:0]         index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic [1:0]         status
);

	localparam int ROWS = (TABLE_SIZE + stli_pkg::ROW_BITS - 1) / stli_pkg::ROW_BITS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW   = RW + stli_pkg::ROW_SHIFT;
	localparam int AW   = $clog2(TABLE_SIZE);
	localparam int PW   = SW + 33;
	localparam int NW   = PW + 1;
	localparam int CW   = $clog2(NW + 1);

	function automatic logic [4:0] top_bit(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int k = 0; k < 32; k++) begin
			if (v[k]) r = 5'(k);
		end
		return r;
	endfunction

	function automatic logic [4:0] low_bit(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int k = 31; k >= 0; k--) begin
			if (v[k]) r = 5'(k);
		end
		return r;
	endfunction

	logic [31:0]        vmem [ROWS];
	logic signed [31:0] dmem [TABLE_SIZE];

	stli_pkg::state_t state_q, state_nx;
	logic [RW-1:0]      row_q, row_nx, clr_q;
	logic [31:0]        vrow_q;
	logic signed [31:0] vdat_q;
	logic               v_we;
	logic [RW-1:0]      v_wa;
	logic [31:0]        v_wd;
	logic [AW-1:0]      d_ra;

	logic               any_q, first_q;
	logic [SW-1:0]      i_q, lo_q, hi_q, d_q;
	logic [4:0]         bit_q;
	logic signed [PW-1:0] p1_q, p2_q;
	logic [NW-1:0]      dq_q;
	logic [SW:0]        rem_q;
	logic               neg_q;
	logic [CW-1:0]      cnt_q;
	logic signed [31:0] res_q;
	logic [1:0]         stat_q;
	logic               ov_q;
	logic signed [31:0] ores_q;
	logic [1:0]         ostat_q;

	logic [SW-1:0]      sa;
	logic               in_range, acc;
	logic [31:0]        lo_m, hi_m;
	logic [SW:0]        trial;
	logic [NW-1:0]      num;
	logic               out_free;

	assign sa       = SW'(index);
	assign in_range = {22'd0, index} < 32'(TABLE_SIZE);
	assign in_stall = (state_q != stli_pkg::S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;

	assign lo_m  = vrow_q & (first_q ? ((32'd1 << bit_q) - 32'd1) : '1);
	assign hi_m  = vrow_q & (first_q ? ~(((32'd1 << bit_q) << 1) - 32'd1) : '1);
	assign trial = {rem_q[SW-1:0], dq_q[NW-1]};
	assign num   = NW'({p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q});

	// Memories: one valid-row read and one value read each cycle.
	always_ff @(posedge clk) begin
		if (v_we) vmem[v_wa] <= v_wd;
		vrow_q <= vmem[row_nx];
		if (acc && func == stli_pkg::FUNC_STORE && in_range) dmem[sa[AW-1:0]] <= value;
		vdat_q <= dmem[d_ra];
	end

	always_comb begin
		state_nx = state_q;
		row_nx   = row_q;
		v_we     = 1'b0;
		v_wa     = row_q;
		v_wd     = vrow_q | (32'd1 << bit_q);
		d_ra     = sa[AW-1:0];
		case (state_q)
			stli_pkg::S_CLR: begin
				v_we = 1'b1;
				v_wa = clr_q;
				v_wd = '0;
				if (clr_q == RW'(ROWS - 1)) state_nx = stli_pkg::S_IDLE;
			end
			stli_pkg::S_IDLE: begin
				if (acc) begin
					row_nx = sa[SW-1:stli_pkg::ROW_SHIFT];
					if (func == stli_pkg::FUNC_STORE) begin
						if (in_range) state_nx = stli_pkg::S_STWR;
					end else if (!any_q || !in_range) begin
						state_nx = stli_pkg::S_FIN;
					end else begin
						state_nx = stli_pkg::S_QHIT;
					end
				end
			end
			stli_pkg::S_STWR: begin
				v_we     = 1'b1;
				state_nx = stli_pkg::S_IDLE;
			end
			stli_pkg::S_QHIT: begin
				if (vrow_q[bit_q]) state_nx = stli_pkg::S_FIN;
				else state_nx = stli_pkg::S_LOSC;
			end
			stli_pkg::S_LOSC: begin
				if (lo_m != '0) begin
					row_nx   = i_q[SW-1:stli_pkg::ROW_SHIFT];
					state_nx = stli_pkg::S_HISC;
				end else if (row_q == '0) begin
					state_nx = stli_pkg::S_FIN;
				end else begin
					row_nx = row_q - RW'(1);
				end
			end
			stli_pkg::S_HISC: begin
				if (hi_m != '0) state_nx = stli_pkg::S_VHI;
				else if (row_q == RW'(ROWS - 1)) state_nx = stli_pkg::S_FIN;
				else row_nx = row_q + RW'(1);
			end
			stli_pkg::S_VHI: begin
				d_ra     = hi_q[AW-1:0];
				state_nx = stli_pkg::S_VLO;
			end
			stli_pkg::S_VLO: begin
				d_ra     = lo_q[AW-1:0];
				state_nx = stli_pkg::S_MUL2;
			end
			stli_pkg::S_MUL2: state_nx = stli_pkg::S_SUM;
			stli_pkg::S_SUM:  state_nx = stli_pkg::S_DIV;
			stli_pkg::S_DIV: begin
				if (cnt_q == CW'(NW)) state_nx = stli_pkg::S_FIN;
			end
			stli_pkg::S_FIN: begin
				if (out_free) state_nx = stli_pkg::S_IDLE;
			end
			default: state_nx = stli_pkg::S_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stli_pkg::S_CLR;
			clr_q   <= '0;
			any_q   <= 1'b0;
			ov_q    <= 1'b0;
			row_q   <= '0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			row_q   <= row_nx;
			if (state_q == stli_pkg::S_CLR) clr_q <= clr_q + RW'(1);
			if (state_q == stli_pkg::S_STWR) any_q <= 1'b1;
			if (state_q == stli_pkg::S_QHIT) first_q <= 1'b1;
			else if (state_q == stli_pkg::S_LOSC) first_q <= (lo_m != '0);
			else if (state_q == stli_pkg::S_HISC) first_q <= 1'b0;
			if (state_q == stli_pkg::S_SUM) cnt_q <= '0;
			else if (state_q == stli_pkg::S_DIV) cnt_q <= cnt_q + CW'(1);
			if (state_q == stli_pkg::S_FIN && out_free) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	// Datapath: neighbor capture, products, sum and restoring divide.
	always_ff @(posedge clk) begin
		if (acc) begin
			i_q   <= sa;
			bit_q <= index[4:0];
			if (!any_q) begin
				res_q  <= '0;
				stat_q <= stli_pkg::ST_EMPTY;
			end else begin
				res_q  <= '0;
				stat_q <= stli_pkg::ST_MISSING;
			end
		end
		case (state_q)
			stli_pkg::S_QHIT: begin
				if (vrow_q[bit_q]) begin
					res_q  <= vdat_q;
					stat_q <= stli_pkg::ST_EXACT;
				end
			end
			stli_pkg::S_LOSC: begin
				if (lo_m != '0) lo_q <= {row_q, top_bit(lo_m)};
			end
			stli_pkg::S_HISC: begin
				if (hi_m != '0) hi_q <= {row_q, low_bit(hi_m)};
			end
			stli_pkg::S_VLO: p1_q <= $signed({1'b0, i_q - lo_q}) * vdat_q;
			stli_pkg::S_MUL2: p2_q <= $signed({1'b0, hi_q - i_q}) * vdat_q;
			stli_pkg::S_SUM: begin
				neg_q <= num[NW-1];
				dq_q  <= num[NW-1] ? (~num + NW'(1)) : num;
				rem_q <= '0;
				d_q   <= hi_q - lo_q;
			end
			stli_pkg::S_DIV: begin
				if (cnt_q == CW'(NW)) begin
					res_q  <= neg_q ? -$signed(dq_q[31:0]) : $signed(dq_q[31:0]);
					stat_q <= stli_pkg::ST_INTERP;
				end else if (trial >= {1'b0, d_q}) begin
					rem_q <= trial - {1'b0, d_q};
					dq_q  <= {dq_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					dq_q  <= {dq_q[NW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
		if (state_q == stli_pkg::S_FIN && out_free) begin
			ores_q  <= res_q;
			ostat_q <= stat_q;
		end
	end

	assign out_valid = ov_q;
	assign result    = ores_q;
	assign status    = ostat_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int SLOTS = 1024;

	typedef struct {
		logic               op;
		logic [9:0]         slot;
		logic signed [31:0] val;
	} req_t;

	typedef struct {
		logic signed [31:0] res;
		logic [1:0]         st;
	} ans_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [9:0]         index;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result;
	logic [1:0]         status;

	sparse_table_linear_interp dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .index(index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .status(status)
	);

	// shadow copy of the table
	logic signed [31:0] shadow_val [SLOTS];
	logic               shadow_ok  [SLOTS];

	req_t pending_items[$];
	ans_t expected_answers[$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_send = 0;
	int  errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  st_seen [4];

	// Predict the answer for one item; return 1 when it produces one.
	function automatic bit interp_predict(input req_t r, output ans_t a);
		int lo, hi, i;
		bit any;
		logic signed [63:0] num, quo;
		any = 0;
		lo = -1;
		hi = -1;
		a.res = '0;
		a.st = stli_pkg::ST_EMPTY;
		if (r.op == stli_pkg::FUNC_STORE) begin
			shadow_val[r.slot] = r.val;
			shadow_ok[r.slot] = 1'b1;
			return 0;
		end
		for (i = 0; i < SLOTS; i++)
			if (shadow_ok[i]) any = 1;
		if (!any) return 1;
		if (shadow_ok[r.slot]) begin
			a.res = shadow_val[r.slot];
			a.st = stli_pkg::ST_EXACT;
			return 1;
		end
		for (i = int'(r.slot) - 1; i >= 0; i--)
			if (shadow_ok[i]) begin
				lo = i;
				break;
			end
		for (i = int'(r.slot) + 1; i < SLOTS; i++)
			if (shadow_ok[i]) begin
				hi = i;
				break;
			end
		if (lo < 0 || hi < 0) begin
			a.st = stli_pkg::ST_MISSING;
			return 1;
		end
		num = 64'(int'(r.slot) - lo) * 64'(shadow_val[hi])
			+ 64'(hi - int'(r.slot)) * 64'(shadow_val[lo]);
		quo = num / 64'(hi - lo);
		a.res = quo[31:0];
		a.st = stli_pkg::ST_INTERP;
		return 1;
	endfunction

	// Clock generation
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Driver: present the head of the queue on the falling edge; advance after accept.
	bit accepted_q = 0;
	always @(posedge clk) begin
		accepted_q <= in_valid && !in_stall && arst_n;
	end

	always @(negedge clk) begin
		ans_t a;
		req_t r;
		if (accepted_q) begin
			r = pending_items.pop_front();
			n_sent++;
			if (interp_predict(r, a)) expected_answers.insert(expected_answers.size(), a);
		end
		// hold a payload that is still waiting
		if (!(in_valid && !accepted_q)) begin
			if (arst_n && !hold_send && pending_items.size() > 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				func     <= pending_items[0].op;
				index    <= pending_items[0].slot;
				value    <= pending_items[0].val;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor: check each output item against the oldest expectation.
	always @(posedge clk) begin
		ans_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected output item result=%0d status=%0d",
					$time, result, status);
				errors++;
			end else begin
				e = expected_answers.pop_front();
				n_checked++;
				st_seen[e.st]++;
				if (result !== e.res) begin
					$display("%0t: result mismatch expected %0d actual %0d",
						$time, e.res, result);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status mismatch expected %0d actual %0d",
						$time, e.st, status);
					errors++;
				end
			end
		end
	end

	task automatic add_item(input logic op, input logic [9:0] s, input logic signed [31:0] v);
		req_t r;
		r.op = op;
		r.slot = s;
		r.val = v;
		pending_items.insert(pending_items.size(), r);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
	endtask

	// Random phase: a random mix of stores (about 40%) and queries, mostly in slots 448..511.
	task automatic random_phase(input int count);
		int k, base;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(9) < 4) begin
				base = $urandom_range(3) == 0 ? $urandom_range(SLOTS - 1)
				                               : $urandom_range(63) + 448;
				add_item(stli_pkg::FUNC_STORE, 10'(base), $urandom());
			end else begin
				base = $urandom_range(3) == 0 ? $urandom_range(SLOTS - 1)
				                               : $urandom_range(63) + 448;
				add_item(stli_pkg::FUNC_QUERY, 10'(base), $urandom());
			end
		end
	endtask

	initial begin
		int ph;
		in_valid = 0;
		func = 0;
		index = '0;
		value = '0;
		out_stall = 0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_ok[i] = 0;
			shadow_val[i] = '0;
		end
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n = 1;

		// Directed: empty table, edges, overwrite, missing sides, extremes.
		add_item(stli_pkg::FUNC_QUERY, 10'd0, 32'sd5);
		add_item(stli_pkg::FUNC_QUERY, 10'd1023, 32'sd0);
		add_item(stli_pkg::FUNC_STORE, 10'd0, 32'sh7fffffff);
		add_item(stli_pkg::FUNC_QUERY, 10'd0, 32'sd0);
		add_item(stli_pkg::FUNC_QUERY, 10'd5, 32'sd0);
		add_item(stli_pkg::FUNC_STORE, 10'd1023, 32'sh80000000);
		add_item(stli_pkg::FUNC_QUERY, 10'd1023, 32'sd0);
		add_item(stli_pkg::FUNC_QUERY, 10'd511, 32'sd0);
		add_item(stli_pkg::FUNC_QUERY, 10'd1, 32'sd0);
		add_item(stli_pkg::FUNC_QUERY, 10'd1022, 32'sd0);
		add_item(stli_pkg::FUNC_STORE, 10'd0, 32'shffffffff);
		add_item(stli_pkg::FUNC_QUERY, 10'd0, 32'sd0);
		add_item(stli_pkg::FUNC_STORE, 10'd100, 32'sd65536);
		add_item(stli_pkg::FUNC_STORE, 10'd103, -32'sd65536);
		add_item(stli_pkg::FUNC_QUERY, 10'd101, 32'sd0);
		add_item(stli_pkg::FUNC_QUERY, 10'd102, 32'sh3ff);
		add_item(stli_pkg::FUNC_QUERY, 10'd700, 32'sd0);
		add_item(stli_pkg::FUNC_STORE, 10'd512, 32'sh55555555);
		add_item(stli_pkg::FUNC_STORE, 10'd513, 32'shaaaaaaaa);
		add_item(stli_pkg::FUNC_QUERY, 10'd512, 32'sd0);
		add_item(stli_pkg::FUNC_QUERY, 10'd513, 32'sd0);
		drain();

		// four random phases with varied sender idle and receiver stall, draining after each
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			random_phase(256);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (200) @(posedge clk);

		$display("Sent %0d items, checked %0d answers", n_sent, n_checked);
		$display("Status mix: exact %0d interp %0d missing %0d empty %0d",
			st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
		if (errors == 0 && expected_answers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Timeout
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/stli_pkg.sv
rtl/sparse_table_linear_interp.sv
verif/tb_top.sv
